/* hw/rtl/vbf_pkg.sv */
// vbf_pkg: widths, constants, register codes and the queue item type of the
// 3x3x3 voxel box filter; shared by every module of the block, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package vbf_pkg;

  // voxel value format
  localparam int unsigned ValueBits = 16;

  // grid limits
  localparam int unsigned MaxX = 64;
  localparam int unsigned MaxY = 64;
  localparam int unsigned XW = $clog2(MaxX);
  localparam int unsigned YW = $clog2(MaxY);
  localparam int unsigned ZW = 10;

  // configuration port
  localparam int unsigned DimXYW   = 7;
  localparam int unsigned DimZW    = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgDimX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDimY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDimZ = 2'd2;

  // running sum widths: 3 taps, 9 taps, 27 taps
  localparam int unsigned RowW   = ValueBits + 2;
  localparam int unsigned PlaneW = ValueBits + 4;
  localparam int unsigned SumW   = ValueBits + 5;

  // line and plane stores, two rows / two planes deep
  localparam int unsigned RowAddrW   = $clog2(2 * MaxX);
  localparam int unsigned PlaneAddrW = $clog2(2 * MaxX * MaxY);

  // rounded divide by 27 as multiply by ceil(2^k/27), exact for SumW-bit inputs
  localparam int unsigned BoxTaps  = 27;
  localparam int unsigned RecipW   = SumW + 1;
  localparam int unsigned DivShift = SumW + 5;
  localparam int unsigned ProdW    = SumW + RecipW;
  localparam logic [RecipW-1:0] DivRecip =
      RecipW'(((64'd1 << DivShift) + 64'(BoxTaps) - 64'd1) / 64'(BoxTaps));
  localparam logic [SumW-1:0] RoundBias = SumW'(BoxTaps / 2);

  // one window sum with its center, handed from front to back
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [XW-1:0]   cx;
    logic [YW-1:0]   cy;
    logic [ZW-1:0]   cz;
    logic            last;
  } vbf_item_t;

endpackage

`default_nettype wire

/* hw/rtl/vbf_front.sv */
// vbf_front: scan position, grid size registers, row and plane sum stores;
// turns each voxel that completes a window into a 27-tap window sum; depends on vbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module vbf_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  input  wire [vbf_pkg::ValueBits-1:0]    sample_value_i,
  output logic                            in_stall_o,
  input  wire                             cfg_we_i,
  input  wire [vbf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [vbf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire                             q_full_i,
  output logic                            push_o,
  output vbf_pkg::vbf_item_t              push_item_o
);
  import vbf_pkg::*;

  logic go, acc;

  // scan position and last coordinate of each axis
  logic [XW-1:0] x_q, x_d, xl_q, xl_d;
  logic [YW-1:0] y_q, y_d, yl_q, yl_d;
  logic [ZW-1:0] z_q, z_d, zl_q, zl_d;

  logic [ValueBits-1:0] prev0_q, prev1_q;

  logic [RowW-1:0]   row_mem [2*MaxX];
  logic [PlaneW-1:0] plane_mem [2*MaxX*MaxY];

  // stage 1
  logic                  s1_rowwr_q, s1_plwr_q, s1_emit_q;
  logic [RowW-1:0]       s1_rs_q, s1_ra_q, s1_rb_q;
  logic [RowAddrW-1:0]   s1_raddr_q;
  logic [PlaneAddrW-1:0] s1_paddr_q;
  logic [PlaneW-1:0]     s1_pa_q, s1_pb_q;
  logic [XW-1:0]         s1_cx_q;
  logic [YW-1:0]         s1_cy_q;
  logic [ZW-1:0]         s1_cz_q;
  logic                  s1_last_q;

  // stage 2
  logic              s2_emit_q;
  logic [PlaneW-1:0] s2_ps_q, s2_pa_q, s2_pb_q;
  logic [XW-1:0]     s2_cx_q;
  logic [YW-1:0]     s2_cy_q;
  logic [ZW-1:0]     s2_cz_q;
  logic              s2_last_q;

  logic [XW-1:0]         cx;
  logic [YW-1:0]         cy;
  logic [RowW-1:0]       rs;
  logic [PlaneW-1:0]     ps;
  logic [RowAddrW-1:0]   r_old, r_mid;
  logic [PlaneAddrW-1:0] p_old, p_mid;
  logic                  x_ge2, y_ge2, z_ge2, at_last;
  logic [DimXYW-1:0]     cfg_xy;
  logic [DimZW-1:0]      cfg_z;

  assign go         = !q_full_i;
  assign acc        = in_valid_i && go;
  assign in_stall_o = q_full_i;

  assign cx    = x_q - XW'(1);
  assign cy    = y_q - YW'(1);
  assign x_ge2 = |x_q[XW-1:1];
  assign y_ge2 = |y_q[YW-1:1];
  assign z_ge2 = |z_q[ZW-1:1];
  assign at_last = (x_q == xl_q) && (y_q == yl_q) && (z_q == zl_q);

  assign rs    = RowW'(sample_value_i) + RowW'(prev0_q) + RowW'(prev1_q);
  assign r_old = {y_q[0], cx};
  assign r_mid = {~y_q[0], cx};
  assign p_old = {z_q[0], cy, cx};
  assign p_mid = {~z_q[0], cy, cx};

  assign ps = PlaneW'(s1_rs_q) + PlaneW'(s1_ra_q) + PlaneW'(s1_rb_q);

  assign cfg_xy = cfg_data_i[DimXYW-1:0];
  assign cfg_z  = cfg_data_i[DimZW-1:0];

  // size registers hold the clamped last coordinate
  always_comb begin
    xl_d = xl_q;
    yl_d = yl_q;
    zl_d = zl_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDimX: begin
          if (cfg_xy < DimXYW'(3)) xl_d = XW'(2);
          else if (cfg_xy > DimXYW'(MaxX)) xl_d = XW'(MaxX - 1);
          else xl_d = XW'(cfg_xy - DimXYW'(1));
        end
        CfgDimY: begin
          if (cfg_xy < DimXYW'(3)) yl_d = YW'(2);
          else if (cfg_xy > DimXYW'(MaxY)) yl_d = YW'(MaxY - 1);
          else yl_d = YW'(cfg_xy - DimXYW'(1));
        end
        CfgDimZ: begin
          if (cfg_z < DimZW'(3)) zl_d = ZW'(2);
          else zl_d = ZW'(cfg_z - DimZW'(1));
        end
        default: ;
      endcase
    end
  end

  // raster advance, restart on any size register write
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (cfg_we_i && (cfg_idx_i == CfgDimX || cfg_idx_i == CfgDimY ||
                     cfg_idx_i == CfgDimZ)) begin
      x_d = '0;
      y_d = '0;
      z_d = '0;
    end else if (acc) begin
      if (x_q == xl_q) begin
        x_d = '0;
        if (y_q == yl_q) begin
          y_d = '0;
          z_d = (z_q == zl_q) ? '0 : z_q + ZW'(1);
        end else begin
          y_d = y_q + YW'(1);
        end
      end else begin
        x_d = x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      z_q        <= '0;
      xl_q       <= XW'(19);
      yl_q       <= YW'(19);
      zl_q       <= ZW'(19);
      s1_rowwr_q <= 1'b0;
      s1_plwr_q  <= 1'b0;
      s1_emit_q  <= 1'b0;
      s2_emit_q  <= 1'b0;
    end else begin
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      xl_q <= xl_d;
      yl_q <= yl_d;
      zl_q <= zl_d;
      if (go) begin
        s1_rowwr_q <= acc && x_ge2;
        s1_plwr_q  <= acc && x_ge2 && y_ge2;
        s1_emit_q  <= acc && x_ge2 && y_ge2 && z_ge2;
        s2_emit_q  <= s1_emit_q;
      end
    end
  end

  // payload and store reads at the transfer edge
  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev0_q    <= sample_value_i;
      prev1_q    <= prev0_q;
      s1_rs_q    <= rs;
      s1_ra_q    <= row_mem[r_old];
      s1_rb_q    <= row_mem[r_mid];
      s1_pa_q    <= plane_mem[p_old];
      s1_pb_q    <= plane_mem[p_mid];
      s1_raddr_q <= r_old;
      s1_paddr_q <= p_old;
      s1_cx_q    <= cx;
      s1_cy_q    <= cy;
      s1_cz_q    <= z_q - ZW'(1);
      s1_last_q  <= at_last;
    end
    if (go) begin
      s2_ps_q   <= ps;
      s2_pa_q   <= s1_pa_q;
      s2_pb_q   <= s1_pb_q;
      s2_cx_q   <= s1_cx_q;
      s2_cy_q   <= s1_cy_q;
      s2_cz_q   <= s1_cz_q;
      s2_last_q <= s1_last_q;
    end
  end

  // store writes: oldest row and plane are overwritten with the new sums
  always_ff @(posedge clk_i) begin
    if (go && s1_rowwr_q) row_mem[s1_raddr_q] <= s1_rs_q;
  end

  always_ff @(posedge clk_i) begin
    if (go && s1_plwr_q) plane_mem[s1_paddr_q] <= ps;
  end

  assign push_o           = go && s2_emit_q;
  assign push_item_o.sum  = SumW'(s2_ps_q) + SumW'(s2_pa_q) + SumW'(s2_pb_q);
  assign push_item_o.cx   = s2_cx_q;
  assign push_item_o.cy   = s2_cy_q;
  assign push_item_o.cz   = s2_cz_q;
  assign push_item_o.last = s2_last_q;

endmodule

`default_nettype wire

/* hw/rtl/vbf_queue.sv */
// vbf_queue: small register queue of window sums between front and back;
// depends on vbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module vbf_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  vbf_pkg::vbf_item_t  push_item_i,
  input  wire                 pop_i,
  output vbf_pkg::vbf_item_t  head_o,
  output logic                nonempty_o,
  output logic                full_o
);
  import vbf_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  vbf_item_t       mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign nonempty_o = (cnt_q != '0);
  assign full_o     = (cnt_q == CntW'(Depth));
  assign head_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    if (pop_i)  rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_item_i;
  end

endmodule

`default_nettype wire

/* hw/rtl/vbf_back.sv */
// vbf_back: rounded divide by 27 of each window sum and the output register;
// depends on vbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module vbf_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          q_nonempty_i,
  input  vbf_pkg::vbf_item_t           q_head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [vbf_pkg::ValueBits-1:0] mean_value_o,
  output logic [vbf_pkg::XW-1:0]       center_x_o,
  output logic [vbf_pkg::YW-1:0]       center_y_o,
  output logic [vbf_pkg::ZW-1:0]       center_z_o,
  output logic                         is_last_o
);
  import vbf_pkg::*;

  logic a_vld_q, b_vld_q, o_vld_q;
  logic a_rdy, b_rdy, o_rdy;

  logic [SumW-1:0]      a_s_q;
  vbf_item_t            a_meta_q, b_meta_q;
  logic [ProdW-1:0]     b_prod_q;
  logic [ValueBits-1:0] o_mean_q;
  vbf_item_t            o_meta_q;

  assign o_rdy = !o_vld_q || !out_stall_i;
  assign b_rdy = !b_vld_q || o_rdy;
  assign a_rdy = !a_vld_q || b_rdy;
  assign pop_o = q_nonempty_i && a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= q_nonempty_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (o_rdy) o_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_s_q    <= q_head_i.sum + RoundBias;
      a_meta_q <= q_head_i;
    end
    if (b_rdy && a_vld_q) begin
      b_prod_q <= ProdW'(a_s_q) * ProdW'(DivRecip);
      b_meta_q <= a_meta_q;
    end
    if (o_rdy && b_vld_q) begin
      o_mean_q <= b_prod_q[DivShift +: ValueBits];
      o_meta_q <= b_meta_q;
    end
  end

  assign out_valid_o  = o_vld_q;
  assign mean_value_o = o_mean_q;
  assign center_x_o   = o_meta_q.cx;
  assign center_y_o   = o_meta_q.cy;
  assign center_z_o   = o_meta_q.cz;
  assign is_last_o    = o_meta_q.last;

endmodule

`default_nettype wire

/* hw/rtl/voxel_box_filter_3d.sv */
// voxel_box_filter_3d: top level of the streaming 3x3x3 box filter
// depends on vbf_pkg, vbf_front, vbf_queue and vbf_back
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3x3 mean filter over a voxel grid sent in raster order (x fastest,
// then y, then z). Grid size is set by three registers (dim_x, dim_y, dim_z;
// reset 20 each, clamped to 3..64, 3..64, 3..1023); any size write restarts the scan
// at the origin and must only happen while the block is idle. For every interior
// voxel one transfer leaves with (sum + 13) / 27 of its neighbourhood, its
// coordinates and a flag on the final one; border voxels give nothing. The block
// takes one voxel per clock. The input stalls only while the result queue
// (QDepth entries) is full because the output side is stalled. After the transfer
// of the voxel that completes its window, a result is registered in turn at the
// store read, the plane sum, the queue entry, the rounding add, the reciprocal
// multiply and the output register; a stall can hold it in any of these.
// No clearing pass is needed after reset.
module voxel_box_filter_3d #(
  parameter int unsigned QDepth = 4
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // voxel input
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [vbf_pkg::ValueBits-1:0]  sample_value_i,
  // filtered output
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [vbf_pkg::ValueBits-1:0] mean_value_o,
  output logic [vbf_pkg::XW-1:0]        center_x_o,
  output logic [vbf_pkg::YW-1:0]        center_y_o,
  output logic [vbf_pkg::ZW-1:0]        center_z_o,
  output logic                          is_last_o,
  // configuration writes
  input  wire                           cfg_we_i,
  input  wire [vbf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [vbf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import vbf_pkg::*;

  // front to queue
  logic      push;
  vbf_item_t push_item;

  // queue to back
  logic      q_full, q_nonempty, pop;
  vbf_item_t q_head;

  // front: scan position, row/plane stores, window sum
  vbf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .sample_value_i (sample_value_i),
    .in_stall_o     (in_stall_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // decoupling queue, lets the front keep going through short output stalls
  vbf_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (q_head),
    .nonempty_o  (q_nonempty),
    .full_o      (q_full)
  );

  // back: reciprocal divide and output register
  vbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (q_nonempty),
    .q_head_i     (q_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mean_value_o (mean_value_o),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .center_z_o   (center_z_o),
    .is_last_o    (is_last_o)
  );

endmodule

`default_nettype wire

/* verif/voxel_box_filter_3d_tb.sv */
// voxel_box_filter_3d_tb: self-checking bench for the streaming 3x3x3 voxel box filter
// depends on vbf_pkg and voxel_box_filter_3d; a small scoreboard class tracks the sums
`timescale 1ns / 1ps

module voxel_box_filter_3d_tb;
  import vbf_pkg::*;

  // cycles to let the pipeline empty before a register write or the end check
  localparam int unsigned SettleCycles = 12;
  // random voxels to send after the directed grids
  localparam int unsigned RandomItems  = 300;
  // receiver hold-off long enough to fill the result queue and stall the input
  localparam int unsigned LongHold     = 80;
  // index 3 of the register port decodes to nothing
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // one filtered voxel as it leaves the block
  typedef struct packed {
    logic [ValueBits-1:0] mean;
    logic [XW-1:0]        cx;
    logic [YW-1:0]        cy;
    logic [ZW-1:0]        cz;
    logic                 last;
  } mean_result_t;

  // keeps its own running sums of the grid and the means still owed by the block
  class voxel_mean_tracker;
    logic [PlaneW-1:0]    plane_sums [2*MaxX*MaxY];
    logic [RowW-1:0]      row_sums [2*MaxX];
    logic [ValueBits-1:0] last_two [2];
    int unsigned          px, py, pz;
    int unsigned          dim_x, dim_y, dim_z;
    mean_result_t         owed_means[$];
    int unsigned          errors;

    function new();
      foreach (plane_sums[i]) plane_sums[i] = '0;
      foreach (row_sums[i]) row_sums[i] = '0;
      last_two[0] = '0;
      last_two[1] = '0;
      px = 0;
      py = 0;
      pz = 0;
      dim_x = 20;
      dim_y = 20;
      dim_z = 20;
      errors = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned grid_voxels();
      return clamp_dim(dim_x, MaxX) * clamp_dim(dim_y, MaxY) * clamp_dim(dim_z, 1023);
    endfunction

    function int unsigned pending();
      return owed_means.size();
    endfunction

    // any write of a size restarts the scan, the spare index is ignored
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgDimX: dim_x = data[DimXYW-1:0];
        CfgDimY: dim_y = data[DimXYW-1:0];
        CfgDimZ: dim_z = data[DimZW-1:0];
        default: return;
      endcase
      px = 0;
      py = 0;
      pz = 0;
    endfunction

    // one accepted voxel: update the separable sums, maybe owe one mean
    function void take_voxel(logic [ValueBits-1:0] value);
      int unsigned  nx, ny, nz, c, r_old, r_mid, off, p_old, p_mid;
      int unsigned  rs, ps, total;
      mean_result_t res;
      nx = clamp_dim(dim_x, MaxX);
      ny = clamp_dim(dim_y, MaxY);
      nz = clamp_dim(dim_z, 1023);
      if (px >= 2) begin
        c = px - 1;
        rs = value + last_two[0] + last_two[1];
        r_old = (py % 2) * MaxX + c;
        r_mid = ((py + 1) % 2) * MaxX + c;
        if (py >= 2) begin
          ps = rs + row_sums[r_old] + row_sums[r_mid];
          off = (py - 1) * MaxX + c;
          p_old = (pz % 2) * MaxX * MaxY + off;
          p_mid = ((pz + 1) % 2) * MaxX * MaxY + off;
          if (pz >= 2) begin
            total = ps + plane_sums[p_old] + plane_sums[p_mid];
            res.mean = ValueBits'((total + BoxTaps / 2) / BoxTaps);
            res.cx = XW'(c);
            res.cy = YW'(py - 1);
            res.cz = ZW'(pz - 1);
            res.last = (px == nx - 1) && (py == ny - 1) && (pz == nz - 1);
            owed_means.insert(owed_means.size(), res);
          end
          plane_sums[p_old] = PlaneW'(ps);
        end
        row_sums[r_old] = RowW'(rs);
      end
      last_two[1] = last_two[0];
      last_two[0] = value;
      px++;
      if (px >= nx) begin
        px = 0;
        py++;
        if (py >= ny) begin
          py = 0;
          pz++;
          if (pz >= nz) pz = 0;
        end
      end
    endfunction

    // one accepted result against the oldest owed mean
    function void check_mean(mean_result_t got);
      mean_result_t want;
      if (owed_means.size() == 0) begin
        $error("unexpected result: mean_value %0d at (%0d,%0d,%0d)",
               got.mean, got.cx, got.cy, got.cz);
        errors++;
        return;
      end
      want = owed_means.pop_front();
      if (got.mean !== want.mean) begin
        $error("mean_value: expected %0d, got %0d", want.mean, got.mean);
        errors++;
      end
      if (got.cx !== want.cx) begin
        $error("center_x: expected %0d, got %0d", want.cx, got.cx);
        errors++;
      end
      if (got.cy !== want.cy) begin
        $error("center_y: expected %0d, got %0d", want.cy, got.cy);
        errors++;
      end
      if (got.cz !== want.cz) begin
        $error("center_z: expected %0d, got %0d", want.cz, got.cz);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("is_last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // every block input holds a known value from time zero
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic [ValueBits-1:0] sample_value_i = '0;
  logic                 out_stall_i    = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i      = '0;
  logic [CfgDataW-1:0]  cfg_data_i     = '0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [ValueBits-1:0] mean_value_o;
  logic [XW-1:0]        center_x_o;
  logic [YW-1:0]        center_y_o;
  logic [ZW-1:0]        center_z_o;
  logic                 is_last_o;

  // calm: no idling on either side; hold_armed: receiver starts its long hold-off
  bit calm       = 1'b0;
  bit hold_armed = 1'b0;

  voxel_mean_tracker tracker = new();

  voxel_box_filter_3d dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_value_o   (mean_value_o),
    .center_x_o     (center_x_o),
    .center_y_o     (center_y_o),
    .center_z_o     (center_z_o),
    .is_last_o      (is_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest passing run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // mostly random voxel values with the extremes mixed in
  function automatic logic [ValueBits-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ValueBits'($urandom);
    endcase
  endfunction

  // mostly small rows and planes, sometimes any raw value incl. out of range
  function automatic logic [CfgDataW-1:0] pick_side();
    if ($urandom_range(0, 9) < 7) return CfgDataW'($urandom_range(3, 6));
    return CfgDataW'($urandom_range(0, 1023));
  endfunction

  function automatic logic [CfgDataW-1:0] pick_depth();
    if ($urandom_range(0, 9) < 8) return CfgDataW'($urandom_range(3, 5));
    return CfgDataW'($urandom_range(0, 1023));
  endfunction

  // one voxel transfer; valid stays high so back-to-back voxels need no gap
  task automatic send_voxel(input logic [ValueBits-1:0] value);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_voxel(value);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // sender goes quiet until every owed mean has come out
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // empty pipeline: voxels that owe nothing may still be in flight
  task automatic settle();
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a run of random voxels in raster order, random sender gaps unless calm, optional midway drain
  task automatic stream_voxels(input int unsigned n_items, input bit pause_midway);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) pause_until_drained();
      if (!calm && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 3));
      send_voxel(pick_value());
    end
  endtask

  // result side: random stall bursts, one long hold-off, check every transfer
  initial begin : result_side
    int unsigned burst_left;
    int unsigned hold_left;
    mean_result_t got;
    burst_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      // the long hold starts once results are flowing so the queue backs up
      if (hold_armed && out_valid_o) begin
        hold_armed = 1'b0;
        hold_left  = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 3) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.mean = mean_value_o;
        got.cx   = center_x_o;
        got.cy   = center_y_o;
        got.cz   = center_z_o;
        got.last = is_last_o;
        tracker.check_mean(got);
      end
    end
  end

  initial begin : stimulus
    int unsigned n_rand;
    int unsigned n_vox;
    int unsigned n_items;
    bit          wrote;
    bit          paused;
    n_rand = 0;
    paused = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // rows of 20 and 20 planes as after reset, only 3 rows per plane so the first
    // interior row comes early; hold the output side during that burst of means
    // so the input has to stall
    write_reg(CfgDimY, 10'd3);
    hold_armed = 1'b1;
    stream_voxels(2 * 60 + 3 * 20, 1'b0);
    settle();

    // sizes below the minimum clamp to a 3x3x3 grid with a single interior voxel
    write_reg(CfgDimX, 10'd0);
    write_reg(CfgDimY, 10'd1);
    write_reg(CfgDimZ, 10'd2);
    // all-ones grid gives the largest sum and the final flag
    repeat (27) send_voxel('1);
    // the scan wraps to a new grid on its own, all zeros this time
    repeat (27) send_voxel('0);
    settle();

    // small grid with a spare-index write mid-scan that must not restart it
    write_reg(CfgDimX, 10'd4);
    write_reg(CfgDimY, 10'd3);
    write_reg(CfgDimZ, 10'd3);
    stream_voxels(20, 1'b0);
    settle();
    write_reg(CfgUnused, CfgDataW'($urandom_range(0, 1023)));
    stream_voxels(16, 1'b0);

    // random grids: full grids with wrap-around, partial scans cut by a rewrite
    while (n_rand < RandomItems) begin
      settle();
      wrote = 1'b0;
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CfgDimX, pick_side());
        wrote = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CfgDimY, pick_side());
        wrote = 1'b1;
      end
      if (!wrote || $urandom_range(0, 2) != 0) write_reg(CfgDimZ, pick_depth());
      n_vox = tracker.grid_voxels();
      if (n_vox <= 400 && $urandom_range(0, 1) == 1) begin
        n_items = n_vox + $urandom_range(0, 20);
      end else begin
        n_items = $urandom_range(20, (n_vox < 300) ? n_vox : 300);
      end
      if (n_items > RandomItems - n_rand) n_items = RandomItems - n_rand;
      // closing stretch runs without idling, other grids sometimes too
      calm = (n_rand + 120 >= RandomItems) || ($urandom_range(0, 3) == 0);
      stream_voxels(n_items, !paused);
      paused = 1'b1;
      n_rand += n_items;
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
